// File: sv/bpfa_pkg.sv
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    localparam int FRAMES     = 65536;
    localparam int WORD_BITS  = 64;
    localparam int NWORDS     = (FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W = $clog2(NWORDS);
    localparam int BIT_IDX_W  = $clog2(WORD_BITS);
    localparam int FRAME_W    = 16;
    localparam int COUNT_W    = 17;
    localparam int LEN_W      = WORD_IDX_W + 1;
    localparam int PADDR_W    = 3;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_FRAME_LIMIT = 3'd0;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_OOM   = 2'd1,
        STAT_FREE  = 2'd2,
        STAT_LIMIT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REL_CHK,
        S_SCAN,
        S_FOUND,
        S_RESP
    } t_state;

    typedef struct packed {
        logic               action;
        logic [FRAME_W-1:0] frame_number;
    } t_in;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        t_status            status;
        logic [COUNT_W-1:0] free_count;
    } t_out;

endpackage

// File: sv/bitmap_page_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Next-fit page frame allocator over a free bitmap held in one RAM.
//
// Input channel (i_in_valid / o_in_stall) carries an action and a frame
// number; output channel (o_out_valid / i_out_stall) returns one beat per
// input beat with frame, status and free count. frame_limit is written over
// the APB port at byte address 0 and read back there.
// After reset the block runs a clearing pass over the 1024 bitmap words, one
// word per cycle, and holds o_in_stall high until that pass is done.
// One item is in work at a time; the RAM's registered read sets the pace.
// Release below the limit: the bitmap word is read, the frame's bit checked
// and set if clear, then the result is registered. Release beyond the limit,
// or allocate with a zero free count or zero limit, goes straight to the result.
// Allocate: the scan reads words from the search start, wrapping at the
// limit, until one holds a free frame, which is then cleared; a scan that
// finds no free frame below the limit answers once every word is checked.
// The next input beat is taken while a result waits; a stalled receiver
// holds back the following result, which waits in the block and stalls input.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator
    import bpfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in                i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out               o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [WORD_BITS-1:0] mem [NWORDS];

    t_state                r_state, n_state;
    logic [COUNT_W-1:0]    r_limit;
    logic [WORD_IDX_W-1:0] r_search, n_search;
    logic [COUNT_W-1:0]    r_free, n_free;
    logic [FRAME_W-1:0]    r_fn, n_fn;
    logic [WORD_IDX_W-1:0] r_addr, n_addr;
    logic [WORD_IDX_W-1:0] r_chk_word, n_chk_word;
    logic [LEN_W-1:0]      r_checked, n_checked;
    logic [WORD_BITS-1:0]  r_data, n_data;
    logic [WORD_BITS-1:0]  r_vhit, n_vhit;
    logic [WORD_IDX_W-1:0] r_clr_addr;
    logic [WORD_BITS-1:0]  r_rdata;
    t_out                  r_res, n_res;
    t_out                  r_out;
    logic                  r_out_valid;

    logic [COUNT_W-1:0]    lim;
    logic [COUNT_W:0]      lim_round;
    logic [LEN_W-1:0]      len;
    logic [WORD_IDX_W-1:0] start;
    logic                  in_accept;
    logic                  out_free;
    logic                  fn_beyond;
    logic                  scan_hit;
    logic                  scan_last;
    logic [WORD_BITS-1:0]  scan_v;
    logic [WORD_BITS-1:0]  hit_onehot;
    logic [BIT_IDX_W-1:0]  hit_bit;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  cfg_wr;

    function automatic logic [WORD_BITS-1:0] word_valid(
        input logic [WORD_IDX_W-1:0] w,
        input logic [COUNT_W-1:0]    l
    );
        logic [COUNT_W-1:0] base;
        logic [COUNT_W-1:0] n;
        base = COUNT_W'({w, {BIT_IDX_W{1'b0}}});
        n    = l - base;
        if (base >= l) begin
            return '0;
        end else if (n >= COUNT_W'(WORD_BITS)) begin
            return '1;
        end else begin
            return (WORD_BITS'(1) << n[BIT_IDX_W-1:0]) - WORD_BITS'(1);
        end
    endfunction

    function automatic logic [WORD_IDX_W-1:0] wrap_next(
        input logic [WORD_IDX_W-1:0] a,
        input logic [LEN_W-1:0]      n
    );
        logic [LEN_W-1:0] a1;
        a1 = {1'b0, a} + LEN_W'(1);
        return (a1 == n) ? '0 : a1[WORD_IDX_W-1:0];
    endfunction

    assign lim       = (r_limit > COUNT_W'(FRAMES)) ? COUNT_W'(FRAMES) : r_limit;
    assign lim_round = {1'b0, lim} + (COUNT_W + 1)'(WORD_BITS - 1);
    assign len       = lim_round[BIT_IDX_W +: LEN_W];
    assign start     = ({1'b0, r_search} < len) ? r_search : '0;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign fn_beyond = {1'b0, i_in.frame_number} >= lim;

    assign scan_v     = r_rdata & word_valid(r_chk_word, lim);
    assign scan_hit   = scan_v != '0;
    assign scan_last  = (r_checked + LEN_W'(1)) == len;
    assign hit_onehot = r_vhit & (~r_vhit + WORD_BITS'(1));

    always_comb begin
        hit_bit = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            hit_bit = hit_bit | (hit_onehot[i] ? BIT_IDX_W'(i) : '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == WORD_IDX_W'(NWORDS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in.action == ACT_RELEASE) begin
                        n_state = fn_beyond ? S_RESP : S_REL_CHK;
                    end else begin
                        n_state = (r_free == '0 || len == '0) ? S_RESP : S_SCAN;
                    end
                end
            end
            S_REL_CHK: n_state = S_RESP;
            S_SCAN: begin
                if (scan_hit)       n_state = S_FOUND;
                else if (scan_last) n_state = S_RESP;
            end
            S_FOUND: n_state = S_RESP;
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_search   = r_search;
        n_free     = r_free;
        n_fn       = r_fn;
        n_addr     = r_addr;
        n_chk_word = r_chk_word;
        n_checked  = r_checked;
        n_data     = r_data;
        n_vhit     = r_vhit;
        n_res      = r_res;
        rd_addr    = r_addr;
        wr_en      = 1'b0;
        wr_addr    = r_clr_addr;
        wr_data    = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                n_fn       = i_in.frame_number;
                n_res      = '{frame: '0, status: STAT_OK, free_count: r_free};
                n_chk_word = start;
                n_addr     = wrap_next(start, len);
                n_checked  = '0;
                if (i_in.action == ACT_RELEASE) begin
                    rd_addr = i_in.frame_number[FRAME_W-1:BIT_IDX_W];
                    if (fn_beyond) n_res.status = STAT_LIMIT;
                end else begin
                    rd_addr = start;
                    if (r_free == '0 || len == '0) n_res.status = STAT_OOM;
                end
            end
            S_REL_CHK: begin
                if (r_rdata[r_fn[BIT_IDX_W-1:0]]) begin
                    n_res.status = STAT_FREE;
                end else begin
                    wr_en            = 1'b1;
                    wr_addr          = r_fn[FRAME_W-1:BIT_IDX_W];
                    wr_data          = r_rdata | (WORD_BITS'(1) << r_fn[BIT_IDX_W-1:0]);
                    n_free           = r_free + COUNT_W'(1);
                    n_res.free_count = r_free + COUNT_W'(1);
                end
            end
            S_SCAN: begin
                rd_addr = r_addr;
                if (scan_hit) begin
                    n_data = r_rdata;
                    n_vhit = scan_v;
                end else begin
                    n_chk_word = r_addr;
                    n_addr     = wrap_next(r_addr, len);
                    n_checked  = r_checked + LEN_W'(1);
                    if (scan_last) n_res.status = STAT_OOM;
                end
            end
            S_FOUND: begin
                wr_en            = 1'b1;
                wr_addr          = r_chk_word;
                wr_data          = r_data & ~hit_onehot;
                n_search         = r_chk_word;
                n_free           = r_free - COUNT_W'(1);
                n_res.free_count = r_free - COUNT_W'(1);
                n_res.frame      = {r_chk_word, hit_bit};
            end
            S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[rd_addr];
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_FRAME_LIMIT[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_limit     <= COUNT_W'(65536);
            r_search    <= '0;
            r_free      <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_search <= n_search;
            r_free   <= n_free;
            if (cfg_wr) r_limit <= pwdata[COUNT_W-1:0];
            if (r_state == S_CLEAR) r_clr_addr <= r_clr_addr + WORD_IDX_W'(1);
            if (r_state == S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fn       <= n_fn;
        r_addr     <= n_addr;
        r_chk_word <= n_chk_word;
        r_checked  <= n_checked;
        r_data     <= n_data;
        r_vhit     <= n_vhit;
        r_res      <= n_res;
        if (r_state == S_RESP && out_free) r_out <= r_res;
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == ADDR_FRAME_LIMIT[2]) ? 32'(r_limit) : '0;

endmodule

// File: sv/bpfa_checker.sv
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level checks for the bitmap page frame allocator.
// ----------------------------------------------------------------------------
module bpfa_checker
    import bpfa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result beat changed");

    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != STAT_OK |-> o_out.frame == '0)
        else $error("failed beat carries a frame");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.free_count <= COUNT_W'(FRAMES))
        else $error("free count above frame total");

endmodule

bind bitmap_page_frame_allocator bpfa_checker u_bpfa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
